### rtl/mbe_pkg.sv
// shared constants, register codes and control types for the escape-time pixel block
// no dependencies; compiled first
package mbe_pkg;

    localparam int XY_W    = 12;
    localparam int CNT_W   = 16;
    localparam int HUE_W   = 8;
    localparam int ORG_W   = 32;
    localparam int STEP_W  = 31;
    localparam int CFG_DW  = 32;
    localparam int CFG_AW  = 3;
    // pixel times step plus origin, signed
    localparam int C_W     = XY_W + STEP_W + 2;
    localparam int CHUNK_W = 32;

    typedef logic [CFG_AW-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_MAX_ITER  = 3'd0;
    localparam cfg_idx_t REG_REAL_ORG  = 3'd1;
    localparam cfg_idx_t REG_IMAG_ORG  = 3'd2;
    localparam cfg_idx_t REG_REAL_STEP = 3'd3;
    localparam cfg_idx_t REG_IMAG_STEP = 3'd4;

    localparam logic [CNT_W-1:0]  RST_MAX_ITER  = 16'd255;
    localparam logic [ORG_W-1:0]  RST_REAL_ORG  = 32'hD800_0000;
    localparam logic [ORG_W-1:0]  RST_IMAG_ORG  = 32'hF000_0000;
    localparam logic [STEP_W-1:0] RST_REAL_STEP = 31'h000E_0000;
    localparam logic [STEP_W-1:0] RST_IMAG_STEP = 31'h000A_AAAB;

    typedef struct packed {
        logic start;
        logic neg;
    } mul_req_t;

endpackage

### rtl/mbe_if.sv
// valid/ready channel interfaces for pixel beats in and result beats out
// depends on mbe_pkg for field widths
interface mbe_pix_if;
    logic                      valid;
    logic                      ready;
    logic [mbe_pkg::XY_W-1:0]  pixel_x;
    logic [mbe_pkg::XY_W-1:0]  pixel_y;

    modport source (output valid, pixel_x, pixel_y, input ready);
    modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface mbe_res_if;
    logic                      valid;
    logic                      ready;
    logic [mbe_pkg::XY_W-1:0]  out_x;
    logic [mbe_pkg::XY_W-1:0]  out_y;
    logic [mbe_pkg::CNT_W-1:0] iteration_count;
    logic                      in_set;
    logic [mbe_pkg::HUE_W-1:0] hue;

    modport source (output valid, out_x, out_y, iteration_count, in_set, hue, input ready);
    modport sink   (input valid, out_x, out_y, iteration_count, in_set, hue, output ready);
endinterface

### rtl/mandelbrot_escape_time_pixel.sv
// escape-time pixel evaluator: maps a pixel to c, iterates z = z*z + c, returns count and hue;
// uses mbe_pkg, mbe_if, mbe_mul and mbe_div. one pixel at a time, one shared multiplier.
// each iteration runs three products, re*re, im*im and 2*re*im, through the multiplier in turn;
// an escape on the squared magnitude ends the iteration after the second product.
// the next pixel is taken as soon as the result sits in the output register.
// async active-low reset clears the sequencer and output valid and loads register defaults.
module mandelbrot_escape_time_pixel #(
    parameter int FRAC_BITS  = 28,
    parameter int COORD_BITS = 12,
    parameter int ITER_BITS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  mbe_pkg::cfg_idx_t         wr_index,
    input  logic [mbe_pkg::CFG_DW-1:0] wr_data,
    mbe_pix_if.sink                   pix,
    mbe_res_if.source                 res
);
    import mbe_pkg::*;

    localparam int OPW = FRAC_BITS + 3;
    localparam int RW  = 2 * OPW - FRAC_BITS + 1;
    localparam int ZW  = ((C_W > FRAC_BITS + 7) ? C_W : FRAC_BITS + 7) + 1;

    localparam logic [XY_W-1:0]       COORD_MASK = XY_W'((32'd1 << COORD_BITS) - 1);
    localparam logic signed [ZW-1:0]  TWO_FX     = ZW'(2) << FRAC_BITS;
    localparam logic signed [ZW-1:0]  NEG_TWO_FX = -TWO_FX;
    localparam logic signed [ZW:0]    FOUR_FX    = (ZW+1)'(4) << FRAC_BITS;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MAP_RE = 4'd1;
    localparam logic [3:0] ST_MAP_IM = 4'd2;
    localparam logic [3:0] ST_CHECK  = 4'd3;
    localparam logic [3:0] ST_W_SR   = 4'd4;
    localparam logic [3:0] ST_W_SI   = 4'd5;
    localparam logic [3:0] ST_W_XI   = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;

    logic [3:0]              state_reg;
    logic [3:0]              state_next;

    logic [ITER_BITS-1:0]    lim_reg;
    logic [ORG_W-1:0]        rorg_reg;
    logic [ORG_W-1:0]        iorg_reg;
    logic [STEP_W-1:0]       rstep_reg;
    logic [STEP_W-1:0]       istep_reg;

    logic [XY_W-1:0]         px_reg;
    logic [XY_W-1:0]         py_reg;
    logic [C_W-1:0]          cre_reg;
    logic [C_W-1:0]          cim_reg;
    logic signed [ZW-1:0]    re_reg;
    logic signed [ZW-1:0]    im_reg;
    logic signed [ZW-1:0]    sr_reg;
    logic signed [ZW-1:0]    si_reg;
    logic [ITER_BITS-1:0]    cnt_reg;

    logic                    ovalid_reg;
    logic [XY_W-1:0]         ox_reg;
    logic [XY_W-1:0]         oy_reg;
    logic [CNT_W-1:0]        ocnt_reg;
    logic                    oset_reg;
    logic [HUE_W-1:0]        ohue_reg;

    logic [XY_W-1:0]         map_px;
    logic [STEP_W-1:0]       map_step;
    logic [ORG_W-1:0]        map_org;
    logic [XY_W+STEP_W-1:0]  map_prod;
    logic [C_W-1:0]          map_c;

    logic signed [ZW-1:0]    cre_ext;
    logic signed [ZW-1:0]    cim_ext;
    logic [ZW-1:0]           re_abs;
    logic [ZW-1:0]           im_abs;
    logic                    z_big;
    logic signed [ZW-1:0]    prod_ext;
    logic signed [ZW:0]      sum_sq;

    mul_req_t                mul_req;
    logic [OPW-1:0]          mul_a;
    logic [OPW-1:0]          mul_b;
    logic                    mul_done;
    logic signed [RW-1:0]    mul_prod;

    logic                    div_start;
    logic                    div_done;
    logic [ITER_BITS+HUE_W-1:0] div_num;
    logic [HUE_W-1:0]        div_quo;

    logic                    out_load;

    // mapping: one small multiply and add per cycle, real part then imaginary part
    assign map_px   = (state_reg == ST_MAP_RE) ? px_reg : py_reg;
    assign map_step = (state_reg == ST_MAP_RE) ? rstep_reg : istep_reg;
    assign map_org  = (state_reg == ST_MAP_RE) ? rorg_reg : iorg_reg;
    assign map_prod = map_px * map_step;
    assign map_c    = {{(C_W-ORG_W){map_org[ORG_W-1]}}, map_org} + C_W'(map_prod);

    assign cre_ext  = {{(ZW-C_W){cre_reg[C_W-1]}}, cre_reg};
    assign cim_ext  = {{(ZW-C_W){cim_reg[C_W-1]}}, cim_reg};
    assign re_abs   = re_reg[ZW-1] ? ZW'(-re_reg) : ZW'(re_reg);
    assign im_abs   = im_reg[ZW-1] ? ZW'(-im_reg) : ZW'(im_reg);
    assign z_big    = (re_reg > TWO_FX) || (re_reg < NEG_TWO_FX)
                   || (im_reg > TWO_FX) || (im_reg < NEG_TWO_FX);
    assign prod_ext = {{(ZW-RW){mul_prod[RW-1]}}, mul_prod};
    assign sum_sq   = {sr_reg[ZW-1], sr_reg} + {prod_ext[ZW-1], prod_ext};

    // 255*count as a shift and subtract
    assign div_num  = {cnt_reg, {HUE_W{1'b0}}} - (ITER_BITS+HUE_W)'(cnt_reg);

    mbe_mul #(
        .OPW       (OPW),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    mbe_div #(
        .ITER_BITS (ITER_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (lim_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next    = state_reg;
        mul_req       = '0;
        mul_a         = re_abs[OPW-1:0];
        mul_b         = re_abs[OPW-1:0];
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix.valid)
                begin
                    state_next = ST_MAP_RE;
                end
            end
            ST_MAP_RE:
            begin
                state_next = ST_MAP_IM;
            end
            ST_MAP_IM:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (cnt_reg >= lim_reg || z_big)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    state_next    = ST_W_SR;
                end
            end
            ST_W_SR:
            begin
                mul_a = im_abs[OPW-1:0];
                mul_b = im_abs[OPW-1:0];
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    state_next    = ST_W_SI;
                end
            end
            ST_W_SI:
            begin
                // cross term uses 2*re, sign from both operands
                mul_a       = {re_abs[OPW-2:0], 1'b0};
                mul_b       = im_abs[OPW-1:0];
                mul_req.neg = re_reg[ZW-1] ^ im_reg[ZW-1];
                if (mul_done)
                begin
                    priority if (sum_sq > FOUR_FX)
                    begin
                        mul_req.neg = 1'b0;
                        div_start   = 1'b1;
                        state_next  = ST_DIV;
                    end
                    else
                    begin
                        mul_req.start = 1'b1;
                        state_next    = ST_W_XI;
                    end
                end
            end
            ST_W_XI:
            begin
                if (mul_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!ovalid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            lim_reg    <= ITER_BITS'(RST_MAX_ITER);
            rorg_reg   <= RST_REAL_ORG;
            iorg_reg   <= RST_IMAG_ORG;
            rstep_reg  <= RST_REAL_STEP;
            istep_reg  <= RST_IMAG_STEP;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_MAX_ITER:  lim_reg   <= ITER_BITS'(wr_data[CNT_W-1:0]);
                    REG_REAL_ORG:  rorg_reg  <= wr_data[ORG_W-1:0];
                    REG_IMAG_ORG:  iorg_reg  <= wr_data[ORG_W-1:0];
                    REG_REAL_STEP: rstep_reg <= wr_data[STEP_W-1:0];
                    REG_IMAG_STEP: istep_reg <= wr_data[STEP_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.valid && pix.ready)
        begin
            px_reg  <= pix.pixel_x & COORD_MASK;
            py_reg  <= pix.pixel_y & COORD_MASK;
            cnt_reg <= '0;
            re_reg  <= '0;
            im_reg  <= '0;
        end
        if (state_reg == ST_MAP_RE)
        begin
            cre_reg <= map_c;
        end
        if (state_reg == ST_MAP_IM)
        begin
            cim_reg <= map_c;
        end
        if (state_reg == ST_W_SR && mul_done)
        begin
            sr_reg <= prod_ext;
        end
        if (state_reg == ST_W_SI && mul_done)
        begin
            si_reg <= prod_ext;
        end
        if (state_reg == ST_W_XI && mul_done)
        begin
            re_reg  <= sr_reg - si_reg + cre_ext;
            im_reg  <= prod_ext + cim_ext;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (out_load)
        begin
            ox_reg   <= px_reg;
            oy_reg   <= py_reg;
            ocnt_reg <= CNT_W'(cnt_reg);
            oset_reg <= (cnt_reg == lim_reg);
            ohue_reg <= (lim_reg == '0) ? '0 : div_quo;
        end
    end

    assign pix.ready           = (state_reg == ST_IDLE);
    assign res.valid           = ovalid_reg;
    assign res.out_x           = ox_reg;
    assign res.out_y           = oy_reg;
    assign res.iteration_count = ocnt_reg;
    assign res.in_set          = oset_reg;
    assign res.hue             = ohue_reg;

    // multiplier results only arrive while the sequencer waits for them
    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_W_SR || state_reg == ST_W_SI || state_reg == ST_W_XI))
        else $error("multiplier result outside a wait state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider result outside the hue state");

    // a stalled result beat is never overwritten
    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && ovalid_reg && !res.ready) |=> (state_reg == ST_FIN))
        else $error("result loaded over a pending beat");

    a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("output valid raised outside the finish state");

endmodule

### rtl/mbe_mul.sv
// shared fixed-point multiplier: magnitude times magnitude, one 32-bit chunk of b per cycle,
// truncated toward zero to FRAC_BITS fraction bits; depends on mbe_pkg
module mbe_mul #(
    parameter int OPW       = 31,
    parameter int FRAC_BITS = 28
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mbe_pkg::mul_req_t             req,
    input  logic [OPW-1:0]                a,
    input  logic [OPW-1:0]                b,
    output logic                          done,
    output logic signed [2*OPW-FRAC_BITS:0] prod
);
    import mbe_pkg::*;

    localparam int NCH  = (OPW + CHUNK_W - 1) / CHUNK_W;
    localparam int BPW  = NCH * CHUNK_W;
    localparam int AW   = OPW + BPW;
    localparam int PW   = 2 * OPW - FRAC_BITS;
    localparam int CNTW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [CNTW-1:0] LAST = CNTW'(NCH - 1);

    logic                  busy_reg;
    logic                  fin_reg;
    logic                  done_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic [OPW-1:0]        a_reg;
    logic [BPW-1:0]        b_reg;
    logic                  neg_reg;
    logic [AW-1:0]         acc_reg;
    logic [PW:0]           prod_reg;

    logic [OPW+CHUNK_W-1:0] partial;
    logic [AW-1:0]          acc_next;
    logic [PW:0]            mag_ext;
    logic [PW:0]            prod_next;

    // most significant chunk first, so the accumulator only ever shifts by a fixed amount
    assign partial   = a_reg * b_reg[BPW-1 -: CHUNK_W];
    assign acc_next  = (acc_reg << CHUNK_W) + AW'(partial);
    assign mag_ext   = {1'b0, acc_reg[FRAC_BITS +: PW]};
    assign prod_next = neg_reg ? (~mag_ext + 1'b1) : mag_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            done_reg <= 1'b0;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        else
        begin
            fin_reg  <= 1'b0;
            done_reg <= fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= a;
            b_reg   <= BPW'(b);
            acc_reg <= '0;
            neg_reg <= req.neg;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << CHUNK_W;
        end
        if (fin_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign done = done_reg;
    assign prod = $signed(prod_reg);

endmodule

### rtl/mbe_div.sv
// restoring divider for the hue: eight quotient bits, one per cycle
// depends on mbe_pkg; numerator must be below den times 256
module mbe_div #(
    parameter int ITER_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [ITER_BITS+mbe_pkg::HUE_W-1:0] num,
    input  logic [ITER_BITS-1:0]               den,
    output logic                               done,
    output logic [mbe_pkg::HUE_W-1:0]          quo
);
    import mbe_pkg::*;

    localparam int CW = $clog2(HUE_W);
    localparam logic [CW-1:0] LAST = CW'(HUE_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CW-1:0]        cnt_reg;
    logic [ITER_BITS-1:0] rem_reg;
    logic [HUE_W-1:0]     num_reg;
    logic [HUE_W-1:0]     quo_reg;

    logic [ITER_BITS:0]   trial;
    logic                 ge;
    logic [ITER_BITS-1:0] rem_next;

    assign trial    = {rem_reg, num_reg[HUE_W-1]};
    assign ge       = trial >= {1'b0, den};
    assign rem_next = ge ? ITER_BITS'(trial - {1'b0, den}) : trial[ITER_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[ITER_BITS+HUE_W-1:HUE_W];
            num_reg <= num[HUE_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[HUE_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
